// ===== rtl/stlp_pkg.sv =====
// Shared types, codes and constants of the string to long parser.
package stlp_pkg;

  // Field widths
  localparam int unsigned ValueW = 64;
  localparam int unsigned BaseW  = 6;
  localparam int unsigned EndW   = 13;
  localparam int unsigned ByteW  = 8;

  // Defaults handed to the top level parameters
  localparam int unsigned MaxLenDef     = 4096;
  localparam int unsigned QueueDepthDef = 2;

  // Radix after reset
  localparam logic [BaseW-1:0] RadixReset = 6'd10;

  // Digit code of a byte that is no digit in any base
  localparam logic [BaseW-1:0] NoDigit = 6'd63;

  // Result status codes
  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StInvalid = 2'd1;
  localparam logic [1:0] StRange   = 2'd2;

  // Classified byte as it travels from front to back
  typedef struct packed {
    logic [BaseW-1:0] digit;   // digit value, NoDigit if none
    logic             blank;   // space, TAB, LF, VT, FF, CR
    logic             plus;
    logic             minus;
    logic             zero_ch; // '0'
    logic             x_ch;    // 'x' or 'X'
    logic             nul;     // zero byte ends the number
    logic             last;
  } class_t;

endpackage

// ===== rtl/stlp_front.sv =====
// Front end: accepts bytes and classifies them for the parser back end.
module stlp_front
  import stlp_pkg::*;
(
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [ByteW-1:0] char_byte_i,
  input  logic             last_i,
  input  logic             q_full_i,
  output logic             push_o,
  output class_t           push_item_o
);

  // Digit value of a byte, letters case-insensitive
  function automatic logic [BaseW-1:0] digit_of(input logic [ByteW-1:0] b);
    logic [BaseW-1:0] d;
    if (b >= 8'h30 && b <= 8'h39) begin
      d = BaseW'(b - 8'h30);
    end else if (b >= 8'h41 && b <= 8'h5A) begin
      d = BaseW'(b - 8'h41 + 8'd10);
    end else if (b >= 8'h61 && b <= 8'h7A) begin
      d = BaseW'(b - 8'h61 + 8'd10);
    end else begin
      d = NoDigit;
    end
    return d;
  endfunction

  // Input handshake: stall only while the queue is full
  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  // Classification
  always_comb begin
    push_item_o.digit   = digit_of(char_byte_i);
    push_item_o.blank   = (char_byte_i == 8'h20) ||
                          (char_byte_i >= 8'h09 && char_byte_i <= 8'h0D);
    push_item_o.plus    = (char_byte_i == 8'h2B);
    push_item_o.minus   = (char_byte_i == 8'h2D);
    push_item_o.zero_ch = (char_byte_i == 8'h30);
    push_item_o.x_ch    = (char_byte_i == 8'h78) || (char_byte_i == 8'h58);
    push_item_o.nul     = (char_byte_i == 8'h00);
    push_item_o.last    = last_i;
  end

endmodule

// ===== rtl/stlp_queue.sv =====
// Short queue of classified items between front and back.
module stlp_queue
  import stlp_pkg::*;
#(
  parameter int unsigned Depth = QueueDepthDef
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  class_t push_item_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   valid_o,
  output class_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  class_t            mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// ===== rtl/stlp_back.sv =====
// Back end: parse state machine, digit accumulation and result register.
module stlp_back
  import stlp_pkg::*;
#(
  parameter int unsigned MaxLen = MaxLenDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [BaseW-1:0]         radix_i,
  input  logic                     q_valid_i,
  input  class_t                   head_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [ValueW-1:0] value_o,
  output logic [1:0]               status_o,
  output logic [EndW-1:0]          end_index_o
);

  localparam int unsigned PosW  = $clog2(MaxLen + 1);
  localparam int unsigned ProdW = ValueW + BaseW + 1;

  // Parse phases
  localparam logic [2:0] PhWs   = 3'd0;
  localparam logic [2:0] PhSign = 3'd1;
  localparam logic [2:0] PhZero = 3'd2;
  localparam logic [2:0] PhHex  = 3'd3;
  localparam logic [2:0] PhDig  = 3'd4;
  localparam logic [2:0] PhDone = 3'd5;

  localparam logic [ValueW-1:0] LimPos = {1'b0, {(ValueW-1){1'b1}}};
  localparam logic [ValueW-1:0] LimNeg = {1'b1, {(ValueW-1){1'b0}}};

  logic [2:0]        phase_q, phase_d;
  logic              neg_q, neg_d;
  logic [ValueW-1:0] acc_q, acc_d;
  logic [BaseW-1:0]  base_q, base_d;
  logic [PosW-1:0]   pos_q, pos_d;
  logic [PosW-1:0]   stop_q, stop_d;
  logic [1:0]        stat_q, stat_d;

  logic                     out_valid_q, out_valid_d;
  logic signed [ValueW-1:0] value_q, value_d;
  logic [1:0]               status_q, status_d;
  logic [EndW-1:0]          end_q, end_d;

  logic [ProdW-1:0]  prod;
  logic [ValueW-1:0] limit;

  // A last item needs the result register free or draining
  assign pop_o = q_valid_i && !(head_i.last && out_valid_q && out_stall_i);

  // One step of the parser per popped item
  always_comb begin
    logic [2:0]       ph;
    logic [BaseW-1:0] tb;
    logic [PosW-1:0]  nxt;
    logic             handled;
    logic             take;
    logic             nodig;
    logic             fin;
    logic [PosW+EndW-1:0] stop_ext;

    phase_d     = phase_q;
    neg_d       = neg_q;
    acc_d       = acc_q;
    base_d      = base_q;
    pos_d       = pos_q;
    stop_d      = stop_q;
    stat_d      = stat_q;
    out_valid_d = out_valid_q && out_stall_i;
    value_d     = value_q;
    status_d    = status_q;
    end_d       = end_q;
    ph          = phase_q;
    tb          = base_q;
    nxt         = (pos_q < PosW'(MaxLen)) ? pos_q + 1'b1 : PosW'(MaxLen);
    handled     = 1'b0;
    take        = 1'b0;
    nodig       = 1'b0;
    fin         = 1'b0;
    limit       = neg_q ? LimNeg : LimPos;
    prod        = '0;
    stop_ext    = '0;

    if (pop_o) begin
      if (ph != PhDone) begin
        if (head_i.nul) begin
          fin = 1'b1;
        end else begin
          pos_d = nxt;
          // whitespace, radix check and sign
          if (ph == PhWs) begin
            handled = 1'b1;
            if (!head_i.blank) begin
              if (radix_i == 6'd1 || radix_i > 6'd36) begin
                stat_d = StInvalid;
                acc_d  = '0;
                stop_d = '0;
                ph     = PhDone;
              end else begin
                tb = radix_i;
                ph = PhSign;
                if (head_i.plus || head_i.minus) begin
                  neg_d = head_i.minus;
                end else begin
                  handled = 1'b0;
                end
              end
            end
          end
          // prefix and digits
          if (!handled) begin
            case (ph)
              PhSign: begin
                if (tb == '0 && head_i.zero_ch) begin
                  stop_d = nxt;
                  ph     = PhZero;
                end else begin
                  if (tb == '0) begin
                    tb = 6'd10;
                  end
                  if (head_i.digit < tb) begin
                    take = 1'b1;
                  end else begin
                    nodig = 1'b1;
                  end
                end
              end
              PhZero: begin
                if (head_i.x_ch) begin
                  tb = 6'd16;
                  ph = PhHex;
                end else begin
                  tb = 6'd8;
                  if (head_i.digit < 6'd8) begin
                    take = 1'b1;
                  end else begin
                    fin = 1'b1;
                  end
                end
              end
              PhHex: begin
                if (head_i.digit < 6'd16) begin
                  take = 1'b1;
                end else begin
                  fin = 1'b1;
                end
              end
              PhDig: begin
                if (head_i.digit < tb) begin
                  take = 1'b1;
                end else begin
                  fin = 1'b1;
                end
              end
              default: begin
              end
            endcase
          end
        end
      end

      // digit accumulation with saturation
      prod = ProdW'(acc_q) * ProdW'(tb) + ProdW'(head_i.digit);
      if (take) begin
        if (stat_q != StRange) begin
          if (prod > ProdW'(limit)) begin
            stat_d = StRange;
            acc_d  = limit;
          end else begin
            acc_d = prod[ValueW-1:0];
          end
        end
        stop_d = nxt;
        ph     = PhDig;
      end
      if (nodig) begin
        stat_d = StOk;
        acc_d  = '0;
        stop_d = '0;
        ph     = PhDone;
      end

      // end of number, by a terminating byte or by the last item
      if (fin || (head_i.last && ph != PhDone)) begin
        if (ph == PhWs || ph == PhSign) begin
          stat_d = StInvalid;
          acc_d  = '0;
          stop_d = '0;
        end else if (ph == PhZero || ph == PhHex) begin
          stat_d = StOk;
          acc_d  = '0;
        end
        ph = PhDone;
      end

      phase_d = ph;
      base_d  = tb;

      // result and per-string clear
      if (head_i.last) begin
        stop_ext    = (PosW + EndW)'(stop_d);
        out_valid_d = 1'b1;
        value_d     = neg_d ? $signed(ValueW'(0) - acc_d) : $signed(acc_d);
        status_d    = stat_d;
        end_d       = stop_ext[EndW-1:0];
        phase_d     = PhWs;
        neg_d       = 1'b0;
        acc_d       = '0;
        base_d      = '0;
        pos_d       = '0;
        stop_d      = '0;
        stat_d      = StOk;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhWs;
      neg_q       <= 1'b0;
      acc_q       <= '0;
      base_q      <= '0;
      pos_q       <= '0;
      stop_q      <= '0;
      stat_q      <= StOk;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      neg_q       <= neg_d;
      acc_q       <= acc_d;
      base_q      <= base_d;
      pos_q       <= pos_d;
      stop_q      <= stop_d;
      stat_q      <= stat_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result register payload
  always_ff @(posedge clk_i) begin
    value_q  <= value_d;
    status_q <= status_d;
    end_q    <= end_d;
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign status_o    = status_q;
  assign end_index_o = end_q;

`ifndef SYNTHESIS
  // A range error always leaves the magnitude pinned at its limit
  a_range_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stat_q == StRange) |-> (acc_q == (neg_q ? LimNeg : LimPos)))
    else $error("range status without saturated magnitude");

  // Position never runs past the maximum length
  a_pos_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos_q <= PosW'(MaxLen)) && (stop_q <= pos_q))
    else $error("position out of range");

  // A last item returns the per-string state to its start
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && head_i.last) |=> (phase_q == PhWs && pos_q == '0 && out_valid_q))
    else $error("string state not cleared after result");

  // An invalid result carries zero value and end position
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q == StInvalid) |-> (value_q == '0 && end_q == '0))
    else $error("invalid result with nonzero payload");

  // A stalled result holds its value
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(value_q)))
    else $error("stalled result changed");
`endif

endmodule

// ===== rtl/string_to_long_parser.sv =====
// Top level of the string to long parser: front, queue, back and radix register.
//
// Converts a byte string to a signed 64-bit integer with strtol rules.
// Input channel: in_valid_i / in_stall_o with char_byte_i and last_i; one
// byte per item, a zero byte ends the number, last_i marks the final byte
// of a string. Output channel: out_valid_o / out_stall_i with value_o,
// status_o (0 ok, 1 invalid, 2 range) and end_index_o; exactly one result
// item per string, produced for the item with last_i set.
// Configuration: cfg_valid_i / cfg_ready_o writes cfg_radix_i (0 auto,
// 2..36); write it only while no string is in flight.
// Throughput: one byte per cycle, unless a stalled result holds back a last
// byte. Each byte costs one pass through the accumulate step (a 64x6
// multiply-add with saturation) in the back end.
// A result is offered once its last byte has passed through the queue and
// the back end has loaded it into the result register.
// Reset: radix returns to 10 and all per-string state clears; no
// clearing pass is needed. When the receiver stalls, the result holds,
// bytes keep flowing until the queue fills and a next last byte waits.
module string_to_long_parser
  import stlp_pkg::*;
#(
  parameter int unsigned MAX_LEN     = MaxLenDef,
  parameter int unsigned QUEUE_DEPTH = QueueDepthDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [BaseW-1:0]         cfg_radix_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [ByteW-1:0]         char_byte_i,
  input  logic                     last_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [ValueW-1:0] value_o,
  output logic [1:0]               status_o,
  output logic [EndW-1:0]          end_index_o
);

  logic [BaseW-1:0] radix_q;
  logic             q_full;
  logic             push;
  class_t           push_item;
  logic             pop;
  logic             q_valid;
  class_t           head;

  // Radix register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= RadixReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      radix_q <= cfg_radix_i;
    end
  end

  stlp_front u_front (
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .char_byte_i (char_byte_i),
    .last_i      (last_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_item_o (push_item)
  );

  stlp_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .head_o      (head)
  );

  stlp_back #(
    .MaxLen (MAX_LEN)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .radix_i     (radix_q),
    .q_valid_i   (q_valid),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .value_o     (value_o),
    .status_o    (status_o),
    .end_index_o (end_index_o)
  );

endmodule

// ===== tb/sv/stlp_checker.sv =====
// Checker for the string to long parser: predicts each conversion and compares results.
module stlp_checker
  import stlp_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  input  logic                     cfg_ready_i,
  input  logic [BaseW-1:0]         cfg_radix_i,
  input  logic                     in_valid_i,
  input  logic                     in_stall_i,
  input  logic [ByteW-1:0]         char_byte_i,
  input  logic                     last_i,
  input  logic                     out_valid_i,
  input  logic                     out_stall_i,
  input  logic signed [ValueW-1:0] value_i,
  input  logic [1:0]               status_i,
  input  logic [EndW-1:0]          end_index_i,
  output int unsigned              fail_count_o,
  output int unsigned              pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned BaseOct  = 8;
  localparam int unsigned BaseDec  = 10;
  localparam int unsigned BaseHex  = 16;
  localparam int unsigned BaseMax  = 36;
  localparam int unsigned PrintCap = 40;

  typedef enum logic [2:0] {
    PhBlank,
    PhSign,
    PhZero,
    PhHex,
    PhDigits,
    PhDone
  } parse_phase_e;

  typedef struct {
    logic signed [ValueW-1:0] value;
    logic [1:0]               status;
    logic [EndW-1:0]          end_index;
  } conv_result_t;

  // Predicted parser state
  logic [BaseW-1:0]  radix_q;
  parse_phase_e      phase_q;
  logic              neg_q;
  logic [ValueW-1:0] mag_q;
  logic [BaseW-1:0]  base_q;
  int unsigned       pos_q;
  int unsigned       stop_q;
  logic [1:0]        stat_q;

  conv_result_t conversions_q[$];
  conv_result_t want;
  logic         produced;

  initial fail_count_o = 0;

  task automatic report_mismatch(input string msg);
    if (fail_count_o < PrintCap) $display("[%0t] mismatch: %s", $time, msg);
    fail_count_o++;
  endtask

  function automatic logic is_blank(input logic [ByteW-1:0] b);
    return b == " " || (b >= 8'd9 && b <= 8'd13);
  endfunction

  function automatic int unsigned digit_value(input logic [ByteW-1:0] b);
    if (b >= "0" && b <= "9") return b - "0";
    if (b >= "A" && b <= "Z") return b - "A" + 10;
    if (b >= "a" && b <= "z") return b - "a" + 10;
    return NoDigit;
  endfunction

  function automatic void clear_string();
    phase_q = PhBlank;
    neg_q   = 1'b0;
    mag_q   = '0;
    base_q  = '0;
    pos_q   = 0;
    stop_q  = 0;
    stat_q  = StOk;
  endfunction

  // Multiply-add of one digit; magnitude sticks at the limit once it overflows
  function automatic void accumulate_digit(input int unsigned d, input int unsigned nxt);
    logic [ValueW-1:0] bound;
    logic [ValueW-1:0] d64;
    logic [ValueW-1:0] b64;
    bound = neg_q ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    d64   = ValueW'(d);
    b64   = ValueW'(base_q);
    if (stat_q != StRange) begin
      if (mag_q > (bound - d64) / b64) begin
        stat_q = StRange;
        mag_q  = bound;
      end else begin
        mag_q = mag_q * b64 + d64;
      end
    end
    stop_q  = nxt;
    phase_q = PhDigits;
  endfunction

  // End of number: nothing seen is invalid, a bare prefix gives zero
  function automatic void close_string();
    if (phase_q == PhBlank || phase_q == PhSign) begin
      stat_q = StInvalid;
      mag_q  = '0;
      stop_q = 0;
    end else if (phase_q == PhZero || phase_q == PhHex) begin
      stat_q = StOk;
      mag_q  = '0;
    end
    phase_q = PhDone;
  endfunction

  function automatic void drop_digits();
    stat_q  = StOk;
    mag_q   = '0;
    stop_q  = 0;
    phase_q = PhDone;
  endfunction

  function automatic void consume_byte(input logic [ByteW-1:0] b, input logic fin,
                                       output logic has_res, output conv_result_t res);
    int unsigned nxt;
    int unsigned d;
    logic        taken;
    has_res = 1'b0;
    res     = '{default: '0};
    if (phase_q != PhDone) begin
      if (b == 8'h00) begin
        close_string();
      end else begin
        nxt   = (pos_q < MaxLenDef) ? pos_q + 1 : MaxLenDef;
        d     = digit_value(b);
        taken = 1'b0;
        pos_q = nxt;
        // radix is sampled at the first byte that is not blank
        if (phase_q == PhBlank) begin
          taken = 1'b1;
          if (!is_blank(b)) begin
            if (radix_q == 1 || radix_q > BaseMax) begin
              stat_q  = StInvalid;
              mag_q   = '0;
              stop_q  = 0;
              phase_q = PhDone;
            end else begin
              base_q  = radix_q;
              phase_q = PhSign;
              if (b == "+" || b == "-") neg_q = (b == "-");
              else taken = 1'b0;
            end
          end
        end
        if (!taken) begin
          case (phase_q)
            PhSign: begin
              if (base_q == 0 && b == "0") begin
                stop_q  = nxt;
                phase_q = PhZero;
              end else begin
                if (base_q == 0) base_q = BaseW'(BaseDec);
                if (d < base_q) accumulate_digit(d, nxt);
                else drop_digits();
              end
            end
            PhZero: begin
              if (b == "x" || b == "X") begin
                base_q  = BaseW'(BaseHex);
                phase_q = PhHex;
              end else begin
                base_q = BaseW'(BaseOct);
                if (d < BaseOct) accumulate_digit(d, nxt);
                else close_string();
              end
            end
            PhHex: begin
              if (d < BaseHex) accumulate_digit(d, nxt);
              else close_string();
            end
            PhDigits: begin
              if (d < base_q) accumulate_digit(d, nxt);
              else close_string();
            end
            default: ;
          endcase
        end
      end
    end
    if (fin) begin
      if (phase_q != PhDone) close_string();
      res.value     = neg_q ? -mag_q : mag_q;
      res.status    = stat_q;
      res.end_index = stop_q[EndW-1:0];
      has_res       = 1'b1;
      clear_string();
    end
  endfunction

  // Compare results first, then fold in this edge's config write and byte
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q = RadixReset;
      clear_string();
      conversions_q.delete();
      pending_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (conversions_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result value %0d status %0d end %0d",
                                    value_i, status_i, end_index_i));
        end else begin
          want = conversions_q.pop_front();
          if (value_i !== want.value)
            report_mismatch($sformatf("value %0d, want %0d", value_i, want.value));
          if (status_i !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", status_i, want.status));
          if (end_index_i !== want.end_index)
            report_mismatch($sformatf("end_index %0d, want %0d", end_index_i,
                                      want.end_index));
        end
      end
      if (cfg_valid_i && cfg_ready_i) radix_q = cfg_radix_i;
      if (in_valid_i && !in_stall_i) begin
        consume_byte(char_byte_i, last_i, produced, want);
        if (produced) conversions_q.push_back(want);
      end
      pending_o = conversions_q.size();
    end
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench top for the string to long parser: clock, reset, stimulus and verdict.
module tb_top
  import stlp_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned BaseOct    = 8;
  localparam int unsigned BaseDec    = 10;
  localparam int unsigned BaseHex    = 16;
  localparam int unsigned BaseMax    = 36;
  localparam int unsigned ByteTarget = 1300;
  localparam int unsigned LongHold   = 80;
  localparam int unsigned DrainLimit = 2000;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_valid_i;
  logic                     cfg_ready_o;
  logic [BaseW-1:0]         cfg_radix_i;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic [ByteW-1:0]         char_byte_i;
  logic                     last_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic signed [ValueW-1:0] value_o;
  logic [1:0]               status_o;
  logic [EndW-1:0]          end_index_o;

  int unsigned fail_count;
  int unsigned pending;

  logic gaps_on       = 1'b1;
  logic stall_on      = 1'b1;
  logic long_hold_req = 1'b0;

  logic [ByteW-1:0] blank_set [6] = '{8'd9, 8'd10, 8'd11, 8'd12, 8'd13, 8'd32};
  int unsigned      radix_plan [12] = '{0, 10, 16, 2, 36, 8, 1, 0, 37, 10, 63, 16};
  logic [ByteW-1:0] text_q[$];

  string_to_long_parser dut (.*);

  stlp_checker checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_radix_i (cfg_radix_i),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .char_byte_i (char_byte_i),
    .last_i      (last_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .value_i     (value_o),
    .status_i    (status_o),
    .end_index_i (end_index_o),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #4ms;
    $display("string_to_long_parser test failed");
    $finish;
  end

  // Result side: short random stall bursts, plus one long hold on request
  initial begin
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (LongHold) @(negedge clk_i);
      end else if (stall_on && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 5)) @(negedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
        @(negedge clk_i);
      end
    end
  end

  // Offer one byte, hold it until taken; returns at a falling edge
  task automatic send_byte(input logic [ByteW-1:0] b, input logic fin);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    char_byte_i <= b;
    last_i      <= fin;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic send_text(input string s, input logic fin = 1'b1);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], fin && i == s.len() - 1);
  endtask

  task automatic send_queue();
    foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1);
  endtask

  // Let every result drain, then write the radix
  task automatic change_radix(input logic [BaseW-1:0] r);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_radix_i <= r;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [ByteW-1:0] digit_char(input int unsigned d);
    if (d < 10) return ByteW'("0" + d);
    return ByteW'(($urandom_range(0, 1) ? "a" : "A") + d - 10);
  endfunction

  // Mostly well-formed numbers with random content; some noise and broken ones
  task automatic compose_string(input logic [BaseW-1:0] r, output int unsigned core_len);
    int unsigned eff_base;
    int unsigned ndig;
    int unsigned sel;
    text_q.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 8)) text_q.push_back(ByteW'($urandom_range(0, 255)));
      core_len = text_q.size();
      return;
    end
    if ($urandom_range(0, 2) == 0)
      repeat ($urandom_range(1, 3)) text_q.push_back(blank_set[$urandom_range(0, 5)]);
    sel = $urandom_range(0, 3);
    if (sel == 1) text_q.push_back("+");
    else if (sel == 2) text_q.push_back("-");
    // a few empty, some long enough to overflow
    sel  = $urandom_range(0, 19);
    ndig = (sel == 0) ? 0 : (sel < 4) ? $urandom_range(20, 70) : $urandom_range(1, 12);
    eff_base = (r >= 2 && r <= BaseMax) ? r : BaseDec;
    if (r == 0) begin
      sel = $urandom_range(0, 2);
      if (sel == 0) begin
        text_q.push_back("0");
        text_q.push_back($urandom_range(0, 1) ? "x" : "X");
        eff_base = BaseHex;
      end else if (sel == 1) begin
        text_q.push_back("0");
        eff_base = BaseOct;
      end else if (ndig != 0) begin
        text_q.push_back(digit_char($urandom_range(1, 9)));
        ndig--;
      end
    end
    repeat (ndig) text_q.push_back(digit_char($urandom_range(0, eff_base - 1)));
    // terminator: end of item, zero byte or any other byte
    sel = $urandom_range(0, 3);
    if (sel == 1) text_q.push_back(8'h00);
    else if (sel == 2) text_q.push_back(ByteW'($urandom_range(1, 255)));
    if (text_q.size() == 0) text_q.push_back(8'h00);
    core_len = text_q.size();
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) text_q.push_back(ByteW'($urandom_range(0, 255)));
  endtask

  initial begin
    int unsigned      core;
    int unsigned      phase_bytes;
    int unsigned      quota;
    int unsigned      random_bytes;
    int unsigned      p;
    logic [BaseW-1:0] r;

    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_radix_i = '0;
    in_valid_i  = 1'b0;
    char_byte_i = '0;
    last_i      = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: empty, blank, sign only, no digits, limits, overflow, trailing bytes
    send_byte(8'h00, 1'b1);
    foreach (blank_set[i]) send_byte(blank_set[i], i == 5);
    send_text("-");
    send_text("+x");
    send_text("9223372036854775807");
    send_text("-9223372036854775808");
    send_text("9223372036854775808");
    send_text("-99999999999999999999");
    send_text("  -42abc");
    send_text("123", 1'b0);
    send_byte(8'h00, 1'b0);
    send_text("456");
    send_text("12", 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b1);

    // Auto base: hex prefix, bare prefix, octal, octal with a bad digit, hex overflow
    change_radix(BaseW'(0));
    send_text("0x1F");
    send_text("0X");
    send_text("0xg");
    send_text("017");
    send_text("08");
    send_text("-0x8000000000000001");

    // Explicit hex takes no prefix
    change_radix(BaseW'(BaseHex));
    send_text("0x1F");
    send_text("fFaA");

    change_radix(BaseW'(BaseMax));
    send_text("zZ");

    change_radix(BaseW'(2));
    repeat (64) send_byte("1", 1'b0);
    send_text("0");

    // Bad radix values
    change_radix(BaseW'(1));
    send_text("  12");
    change_radix(BaseW'(37));
    send_text("7");
    change_radix(BaseW'(63));
    send_text("7");

    // Random phases, one radix each
    random_bytes = 0;
    p = 0;
    while (random_bytes < ByteTarget) begin
      r = (p < 12) ? BaseW'(radix_plan[p]) : BaseW'($urandom_range(0, 63));
      change_radix(r);
      quota = (r == 1 || r > BaseMax) ? 60 : 150;
      if (random_bytes > ByteTarget - 200) begin
        gaps_on  = 1'b0;
        stall_on = 1'b0;
      end else if (p == 3) begin
        // receiver holds off while bytes keep coming
        gaps_on       = 1'b0;
        stall_on      = 1'b1;
        long_hold_req = 1'b1;
      end else begin
        gaps_on  = ($urandom_range(0, 3) != 0);
        stall_on = ($urandom_range(0, 3) != 0);
      end
      phase_bytes = 0;
      while (phase_bytes < quota && random_bytes < ByteTarget) begin
        compose_string(r, core);
        send_queue();
        phase_bytes += core;
        random_bytes += core;
      end
      p++;
    end

    in_valid_i <= 1'b0;
    for (int i = 0; i < DrainLimit && pending != 0; i++) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    if (pending != 0) $display("%0d results never arrived", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("string_to_long_parser test passed");
    end else begin
      $display("string_to_long_parser test failed");
    end
    $finish;
  end

endmodule

// ===== string_to_long_parser.f =====
rtl/stlp_pkg.sv
rtl/stlp_front.sv
rtl/stlp_queue.sv
rtl/stlp_back.sv
rtl/string_to_long_parser.sv
tb/sv/stlp_checker.sv
tb/sv/tb_top.sv
